@@ design/srm_pkg.sv @@
// Package for the surface-of-revolution mesher: sizes, register codes,
// quarter-wave sine table, rounding helper and the sequencer microprogram.
// No dependencies.
package srm_pkg;

  localparam int MAX_RESOLUTION   = 16;
  localparam int MAX_POINTS       = 256;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int RES_CAP = (MAX_RESOLUTION < 16) ? MAX_RESOLUTION : 16;

  localparam int RES_W      = 5;
  localparam int PHASE_W    = 15;
  localparam int COORD_W    = 16;
  localparam int VIDX_W     = 14;
  localparam int BAND_W     = 8;
  localparam int ANGLE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int PCNT_W     = $clog2(MAX_POINTS);
  localparam int STEP_W     = $clog2(RES_CAP);

  localparam int SINE_W     = 18;
  localparam int PROD_W     = COORD_W + SINE_W;
  localparam int TAB_IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int POS_W      = 14;
  localparam int POS_PROD_W = POS_W + TAB_IDX_W;

  localparam logic [RES_W-1:0]     RES_RESET   = RES_W'(8);
  localparam logic [PHASE_W-1:0]   PHASE_RESET = PHASE_W'(8192);
  localparam logic [RES_W-1:0]     RES_MIN     = RES_W'(3);
  localparam logic [RES_W-1:0]     RES_MAX     = RES_W'(RES_CAP);
  localparam logic [ANGLE_W-1:0]   QUARTER_TURN = ANGLE_W'(16384);
  localparam logic [TAB_IDX_W-1:0] TAB_TOP     = TAB_IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [PCNT_W-1:0]    PCNT_LAST   = PCNT_W'(MAX_POINTS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESOLUTION  = 2'd0,
    REG_SMOOTH_MODE = 2'd1,
    REG_PHASE_STEP  = 2'd2
  } cfg_reg_t;

  // quarter-wave sine, Q16, built at elaboration with Q30 Horner series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [7:0]  SERIES_DIV [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  typedef logic [16:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x  = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int k = 0; k < 6; k++) begin
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'(SERIES_DIV[k]);
      end
      s = (x * t) >> 30;
      tab[i] = 17'((s + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic logic signed [SINE_W-1:0] sine_q16(logic [ANGLE_W-1:0] angle);
    logic [1:0]                quad;
    logic [POS_W-1:0]          pos;
    logic [POS_PROD_W-1:0]     prod;
    logic [TAB_IDX_W-1:0]      idx;
    logic signed [SINE_W-1:0]  mag;
    quad = angle[ANGLE_W-1:ANGLE_W-2];
    pos  = angle[POS_W-1:0];
    prod = POS_PROD_W'(pos) * POS_PROD_W'(SINE_TABLE_DEPTH) + POS_PROD_W'(8192);
    if (prod[POS_PROD_W-1:POS_W] > TAB_TOP) begin
      idx = TAB_TOP;
    end else begin
      idx = prod[POS_PROD_W-1:POS_W];
    end
    if (quad[0]) begin
      idx = TAB_TOP - idx;
    end
    mag = $signed({1'b0, SINE_TAB[idx]});
    return quad[1] ? -mag : mag;
  endfunction

  // Q8.8 x Q16 -> Q8.8, half rounds up, saturated
  function automatic logic signed [COORD_W-1:0] round_sat(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0]         s;
    logic signed [PROD_W-COORD_W:0] q;
    logic signed [COORD_W-1:0]      r;
    s = {p[PROD_W-1], p} + (PROD_W+1)'(32768);
    q = s[PROD_W:COORD_W];
    if (q > (PROD_W-COORD_W+1)'(32767)) begin
      r = 16'sh7FFF;
    end else if (q < -(PROD_W-COORD_W+1)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[COORD_W-1:0];
    end
    return r;
  endfunction

  // microprogram
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_STEP_MORE,
    C_EMPTY,
    C_NO_QUADS,
    C_QUADS
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  set_base;
    logic  look;
    logic  mult;
    logic  put_vert;
    logic  put_quad;
    logic  next_src;
    logic  commit;
    logic  wait_out;
    cond_t cond;
    upc_t  target;
  } uword_t;

  localparam upc_t UA_IDLE  = 4'd0;
  localparam upc_t UA_LOOK  = 4'd2;
  localparam upc_t UA_RING2 = 4'd7;
  localparam upc_t UA_QUAD  = 4'd8;
  localparam upc_t UA_DONE  = 4'd9;

  //  take set  look mult vert quad src  cmt  wait  cond         target
  localparam uword_t UCODE [2**UPC_W] = '{
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_NO_INPUT,  UA_IDLE},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_EMPTY,     UA_DONE},
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_NEVER,     UA_IDLE},
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_NEVER,     UA_IDLE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, C_STEP_MORE, UA_LOOK},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_NO_QUADS,  UA_DONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_QUADS,     UA_QUAD},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, C_ALWAYS,    UA_LOOK},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, C_STEP_MORE, UA_QUAD},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, C_ALWAYS,    UA_IDLE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    UA_IDLE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    UA_IDLE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    UA_IDLE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    UA_IDLE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    UA_IDLE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    UA_IDLE}
  };

endpackage

@@ design/srm_if.sv @@
// Channel interfaces of the surface-of-revolution mesher: profile points in,
// mesh results out, register writes. Depends on srm_pkg.
interface srm_point_if import srm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] axial_pos;
  logic signed [COORD_W-1:0] radius;
  logic                      end_of_profile;

  modport source (output valid, axial_pos, radius, end_of_profile, input ready);
  modport sink   (input valid, axial_pos, radius, end_of_profile, output ready);
endinterface

interface srm_mesh_if import srm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      item_kind;
  logic [VIDX_W-1:0]         vertex_index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [BAND_W-1:0]         band_index;
  logic [VIDX_W-1:0]         corner_a;
  logic [VIDX_W-1:0]         corner_b;
  logic [VIDX_W-1:0]         corner_c;
  logic [VIDX_W-1:0]         corner_d;
  logic                      last_of_run;

  modport source (output valid, item_kind, vertex_index, coord_x, coord_y, coord_z,
                  band_index, corner_a, corner_b, corner_c, corner_d, last_of_run,
                  input ready);
  modport sink   (input valid, item_kind, vertex_index, coord_x, coord_y, coord_z,
                  band_index, corner_a, corner_b, corner_c, corner_d, last_of_run,
                  output ready);
endinterface

interface srm_cfg_if import srm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/surface_of_revolution_mesher.sv @@
// Surface-of-revolution mesher: microcoded sequencer, sine lookup, two
// multipliers and an output register. Depends on srm_pkg and srm_if.
//
// Usage:
//   profile: one (axial_pos, radius, end_of_profile) point per transfer.
//   mesh:    vertex and quad results, one per transfer, last_of_run marks
//            the final result of a point.
//   cfg:     register writes (resolution, smooth_mode, phase_step), ready
//            outside reset; write only between points.
// Steps: a vertex passes lookup, multiply and output load, a quad only the
// output load. Overhead per point: accept, setup, two dispatch steps and
// commit, plus a source switch and a second dispatch pass for the second
// ring in faceted mode. A profile's first point gives only vertices in
// smooth mode and no results in faceted mode. The first result of a point
// follows setup, lookup and multiply. The output register holds a result
// until taken; a stalled receiver halts the sequencer at the next emit
// step. The next point is accepted while the last result still waits.
// Reset: registers return to R=8, smooth mode, phase 8192; point counter
// and stored previous point clear.
module surface_of_revolution_mesher import srm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  srm_point_if.sink   profile,
  srm_mesh_if.source  mesh,
  srm_cfg_if.sink     cfg
);

  logic [RES_W-1:0]   cfg_resolution;
  logic               cfg_smooth;
  logic [PHASE_W-1:0] cfg_phase;

  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   stall;
  logic   jump;

  logic signed [COORD_W-1:0] cur_axial;
  logic signed [COORD_W-1:0] cur_radius;
  logic                      cur_eop;
  logic signed [COORD_W-1:0] prev_axial;
  logic signed [COORD_W-1:0] prev_radius;
  logic [PCNT_W-1:0]         point_count;

  logic                      ring_sel;
  logic [VIDX_W-1:0]         base;
  logic [STEP_W-1:0]         step;
  logic [ANGLE_W-1:0]        angle;
  logic signed [SINE_W-1:0]  sin_v;
  logic signed [SINE_W-1:0]  cos_v;
  logic signed [PROD_W-1:0]  prod_y;
  logic signed [PROD_W-1:0]  prod_z;

  logic                      ovalid;
  logic                      o_kind;
  logic [VIDX_W-1:0]         o_vidx;
  logic signed [COORD_W-1:0] o_x;
  logic signed [COORD_W-1:0] o_y;
  logic signed [COORD_W-1:0] o_z;
  logic [BAND_W-1:0]         o_band;
  logic [VIDX_W-1:0]         o_a;
  logic [VIDX_W-1:0]         o_b;
  logic [VIDX_W-1:0]         o_c;
  logic [VIDX_W-1:0]         o_d;
  logic                      o_last;

  logic [RES_W-1:0]          res_eff;
  logic                      step_last;
  logic [STEP_W-1:0]         step_wrap;
  logic [PCNT_W:0]           ring_first;
  logic [PCNT_W+RES_W:0]     ring_base_full;
  logic [VIDX_W-1:0]         res_v;
  logic [VIDX_W-1:0]         lower;
  logic signed [COORD_W-1:0] src_axial;
  logic signed [COORD_W-1:0] src_radius;
  logic                      first_point;

  // config registers
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_resolution <= RES_RESET;
      cfg_smooth     <= 1'b1;
      cfg_phase      <= PHASE_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_RESOLUTION:  cfg_resolution <= cfg.data[RES_W-1:0];
        REG_SMOOTH_MODE: cfg_smooth     <= cfg.data[0];
        REG_PHASE_STEP:  cfg_phase      <= cfg.data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_resolution < RES_MIN) begin
      res_eff = RES_MIN;
    end else if (cfg_resolution > RES_MAX) begin
      res_eff = RES_MAX;
    end else begin
      res_eff = cfg_resolution;
    end
  end

  // sequencer
  assign uw = UCODE[upc];
  assign profile.ready = uw.take_in && !rst;
  assign stall = uw.wait_out && ovalid && !mesh.ready;

  assign first_point = (point_count == '0);
  assign step_last   = (RES_W'(step) == res_eff - RES_W'(1));
  assign step_wrap   = step_last ? '0 : step + STEP_W'(1);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_INPUT:  jump = !profile.valid;
      C_STEP_MORE: jump = !step_last;
      C_EMPTY:     jump = !cfg_smooth && first_point;
      C_NO_QUADS:  jump = cfg_smooth && first_point;
      C_QUADS:     jump = cfg_smooth || ring_sel;
      default:     jump = 1'b0;
    endcase
    if (stall) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // datapath
  assign ring_first     = cfg_smooth ? {1'b0, point_count} : {point_count - PCNT_W'(1), 1'b0};
  assign ring_base_full = ring_first * res_eff;
  assign res_v          = VIDX_W'(res_eff);
  assign lower          = base - res_v;
  assign src_axial      = ring_sel ? cur_axial : prev_axial;
  assign src_radius     = ring_sel ? cur_radius : prev_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_axial  <= '0;
      prev_radius <= '0;
      point_count <= '0;
    end else if (uw.commit) begin
      prev_axial  <= cur_axial;
      prev_radius <= cur_radius;
      if (cur_eop || point_count == PCNT_LAST) begin
        point_count <= '0;
      end else begin
        point_count <= point_count + PCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uw.take_in && profile.valid) begin
      cur_axial  <= profile.axial_pos;
      cur_radius <= profile.radius;
      cur_eop    <= profile.end_of_profile;
    end
    if (uw.set_base) begin
      base     <= VIDX_W'(ring_base_full);
      ring_sel <= cfg_smooth;
      step     <= '0;
      angle    <= '0;
    end
    if (uw.next_src) begin
      base     <= base + res_v;
      ring_sel <= 1'b1;
    end
    if (uw.look) begin
      sin_v <= sine_q16(angle);
      cos_v <= sine_q16(angle + QUARTER_TURN);
    end
    if (uw.mult) begin
      prod_y <= src_radius * sin_v;
      prod_z <= src_radius * cos_v;
    end
    if (!stall && (uw.put_vert || uw.put_quad)) begin
      step  <= step_wrap;
      angle <= step_last ? '0 : angle + ANGLE_W'(cfg_phase);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (!stall && (uw.put_vert || uw.put_quad)) begin
      ovalid <= 1'b1;
    end else if (mesh.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && uw.put_vert) begin
      o_kind <= 1'b0;
      o_vidx <= base + VIDX_W'(step);
      o_x    <= src_axial;
      o_y    <= round_sat(prod_y);
      o_z    <= round_sat(prod_z);
      o_band <= '0;
      o_a    <= '0;
      o_b    <= '0;
      o_c    <= '0;
      o_d    <= '0;
      o_last <= cfg_smooth && first_point && step_last;
    end else if (!stall && uw.put_quad) begin
      o_kind <= 1'b1;
      o_vidx <= '0;
      o_x    <= '0;
      o_y    <= '0;
      o_z    <= '0;
      o_band <= BAND_W'(point_count - PCNT_W'(1));
      o_a    <= lower + VIDX_W'(step);
      o_b    <= base + VIDX_W'(step);
      o_c    <= base + VIDX_W'(step_wrap);
      o_d    <= lower + VIDX_W'(step_wrap);
      o_last <= step_last;
    end
  end

  assign mesh.valid        = ovalid;
  assign mesh.item_kind    = o_kind;
  assign mesh.vertex_index = o_vidx;
  assign mesh.coord_x      = o_x;
  assign mesh.coord_y      = o_y;
  assign mesh.coord_z      = o_z;
  assign mesh.band_index   = o_band;
  assign mesh.corner_a     = o_a;
  assign mesh.corner_b     = o_b;
  assign mesh.corner_c     = o_c;
  assign mesh.corner_d     = o_d;
  assign mesh.last_of_run  = o_last;

endmodule
